// File: rtl/rsmfs_pkg.sv
package rsmfs_pkg;

  // default sizes
  localparam int NUM_REGS_DEF  = 14;
  localparam int SLOT_BITS_DEF = 16;

  // register number width on the ports and in the fifo cells (up to 16 registers)
  localparam int REG_W = 4;
  // fifo fill count width, holds 0..16
  localparam int CNT_W = 5;

  typedef logic [REG_W-1:0] reg_idx_t;
  typedef logic [CNT_W-1:0] fifo_cnt_t;

  // request codes
  typedef enum logic {
    OP_GET     = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // update command broadcast to every fifo cell
  typedef struct packed {
    logic      upd;    // remove key wherever it sits, then append it
    reg_idx_t  key;    // register to move to the back
    fifo_cnt_t count;  // current fill
    fifo_cnt_t wpos;   // position the key lands in
  } fifo_cmd_t;

  // write command to the register bank
  typedef struct packed {
    logic     take;  // map idx to the new slot
    logic     drop;  // unmap idx
    reg_idx_t idx;
  } bank_cmd_t;

  // sort key of a register number by its decimal text
  function automatic int text_key(input int n);
    if (n < 10) begin
      return n * 16;
    end
    return 17 + (n - 10);
  endfunction

  // register number that sits at text rank k among 0..n-1
  function automatic int reg_at_rank(input int k, input int n);
    int cnt;
    int res;
    res = 0;
    for (int j = 0; j < n; j++) begin
      cnt = 0;
      for (int i = 0; i < n; i++) begin
        if (text_key(i) < text_key(j)) begin
          cnt++;
        end
      end
      if (cnt == k) begin
        res = j;
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/rsmfs_fifo_cell.sv
module rsmfs_fifo_cell #(
  parameter int POS = 0
) (
  input  logic                 clk,
  input  rsmfs_pkg::fifo_cmd_t cmd,
  input  rsmfs_pkg::reg_idx_t  nb_entry,
  input  logic                 shift_in,
  output rsmfs_pkg::reg_idx_t  entry,
  output logic                 shift_out
);

  rsmfs_pkg::reg_idx_t entry_r;
  rsmfs_pkg::reg_idx_t entry_nxt;
  logic                occ;
  logic                match;

  // this position is filled and holds the key
  assign occ       = rsmfs_pkg::CNT_W'(POS) < cmd.count;
  assign match     = occ && (entry_r == cmd.key);
  // every cell from the key's position onward pulls from its neighbor
  assign shift_out = shift_in | match;

  // append wins over the shift
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.upd) begin
      if (cmd.wpos == rsmfs_pkg::CNT_W'(POS)) begin
        entry_nxt = cmd.key;
      end else if (shift_out) begin
        entry_nxt = nb_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: rtl/rsmfs_reg_bank.sv
module rsmfs_reg_bank #(
  parameter int NUM_REGS  = rsmfs_pkg::NUM_REGS_DEF,
  parameter int SLOT_BITS = rsmfs_pkg::SLOT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rsmfs_pkg::bank_cmd_t cmd,
  input  logic [SLOT_BITS-1:0] slot,
  input  rsmfs_pkg::reg_idx_t  rd_idx,
  output logic [SLOT_BITS-1:0] rd_slot,
  output logic [NUM_REGS-1:0]  mapped_vec,
  output logic [NUM_REGS-1:0]  free_vec,
  output logic                 found,
  output rsmfs_pkg::reg_idx_t  found_idx,
  output logic                 free_any,
  output rsmfs_pkg::reg_idx_t  free_idx
);

  localparam int IDX_W = $clog2(NUM_REGS);

  logic [SLOT_BITS-1:0] slot_r [NUM_REGS];
  logic [NUM_REGS-1:0]  mapped_r, mapped_nxt;
  logic [NUM_REGS-1:0]  free_r, free_nxt;
  logic [NUM_REGS-1:0]  hit_vec;
  logic [NUM_REGS-1:0]  rank_free;

  // associative compare against every mapped register
  for (genvar i = 0; i < NUM_REGS; i++) begin : g_cmp
    assign hit_vec[i] = mapped_r[i] && (slot_r[i] == slot);
  end

  // free flags put in text order
  for (genvar k = 0; k < NUM_REGS; k++) begin : g_rank
    localparam int RR = rsmfs_pkg::reg_at_rank(k, NUM_REGS);
    assign rank_free[k] = free_r[RR];
  end

  // lowest matching register
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        found     = 1'b1;
        found_idx = rsmfs_pkg::REG_W'(i);
      end
    end
  end

  // first free register in text order
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int k = NUM_REGS - 1; k >= 0; k--) begin
      if (rank_free[k]) begin
        free_any = 1'b1;
        free_idx = rsmfs_pkg::REG_W'(rsmfs_pkg::reg_at_rank(k, NUM_REGS));
      end
    end
  end

  // flag updates
  always_comb begin
    mapped_nxt = mapped_r;
    free_nxt   = free_r;
    if (cmd.take) begin
      mapped_nxt[cmd.idx[IDX_W-1:0]] = 1'b1;
      free_nxt[cmd.idx[IDX_W-1:0]]   = 1'b0;
    end else if (cmd.drop) begin
      mapped_nxt[cmd.idx[IDX_W-1:0]] = 1'b0;
      free_nxt[cmd.idx[IDX_W-1:0]]   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_r <= '0;
      free_r   <= '1;
    end else begin
      mapped_r <= mapped_nxt;
      free_r   <= free_nxt;
    end
  end

  // slot numbers, written on a fresh mapping
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      slot_r[cmd.idx[IDX_W-1:0]] <= slot;
    end
  end

  assign rd_slot    = slot_r[rd_idx[IDX_W-1:0]];
  assign mapped_vec = mapped_r;
  assign free_vec   = free_r;

endmodule

// File: rtl/register_slot_map_fifo_spill_unit.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_op, in_mem_slot, in_no_load
// out      output     out_valid / out_stall out_reg_index, out_hit, out_spill_valid,
//                                           out_spill_slot, out_load_valid
//
// one beat per cycle while in_stall is low: lookup, selection and fifo update settle in the
// cycle a beat is accepted; the result appears in the next cycle in the output register.
// the ripple of the move-to-back shift along the fifo cell row sets the cycle time.
// in_stall rises only while a finished result waits under out_stall.
// rst_n (synchronous) empties the fifo and frees all registers; no clearing pass.
module register_slot_map_fifo_spill_unit #(
  parameter int NUM_REGS  = rsmfs_pkg::NUM_REGS_DEF,
  parameter int SLOT_BITS = rsmfs_pkg::SLOT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [SLOT_BITS-1:0] in_mem_slot,
  input  logic                 in_no_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_reg_index,
  output logic                 out_hit,
  output logic                 out_spill_valid,
  output logic [SLOT_BITS-1:0] out_spill_slot,
  output logic                 out_load_valid
);

  localparam int IDX_W = $clog2(NUM_REGS);

  rsmfs_pkg::bank_cmd_t bank_cmd;
  rsmfs_pkg::fifo_cmd_t fifo_cmd;
  rsmfs_pkg::reg_idx_t  ent [NUM_REGS];
  logic [NUM_REGS:0]    sh;
  logic [SLOT_BITS-1:0] rd_slot;
  logic [NUM_REGS-1:0]  mapped_vec;
  logic [NUM_REGS-1:0]  free_vec;
  logic                 found, free_any;
  rsmfs_pkg::reg_idx_t  found_idx, free_idx, tgt;

  rsmfs_pkg::fifo_cnt_t count_r, count_nxt;
  logic                 accept, is_get, miss, fifo_busy, take_ok, rel, spill, in_fifo;

  logic                 out_valid_r, out_valid_nxt;
  logic [3:0]           out_reg_index_r;
  logic                 out_hit_r, out_spill_valid_r, out_load_valid_r;
  logic [SLOT_BITS-1:0] out_spill_slot_r;

  // register bank: slot numbers and flags
  rsmfs_reg_bank #(
    .NUM_REGS  (NUM_REGS),
    .SLOT_BITS (SLOT_BITS)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (bank_cmd),
    .slot       (in_mem_slot),
    .rd_idx     (ent[0]),
    .rd_slot    (rd_slot),
    .mapped_vec (mapped_vec),
    .free_vec   (free_vec),
    .found      (found),
    .found_idx  (found_idx),
    .free_any   (free_any),
    .free_idx   (free_idx)
  );

  // fifo order as a row of cells, front at cell 0
  assign sh[0] = 1'b0;
  for (genvar i = 0; i < NUM_REGS; i++) begin : g_cell
    rsmfs_pkg::reg_idx_t nb;
    if (i < NUM_REGS - 1) begin : g_mid
      assign nb = ent[i+1];
    end else begin : g_last
      assign nb = '0;
    end
    rsmfs_fifo_cell #(
      .POS (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (fifo_cmd),
      .nb_entry  (nb),
      .shift_in  (sh[i]),
      .entry     (ent[i]),
      .shift_out (sh[i+1])
    );
  end

  // request decode
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign is_get    = (in_op == rsmfs_pkg::OP_GET);
  assign miss      = accept & is_get & ~found;
  assign fifo_busy = (count_r != '0);
  assign take_ok   = miss & (free_any | fifo_busy);
  assign rel       = accept & ~is_get & found;
  // free register first, else the fifo front
  assign tgt       = free_any ? free_idx : ent[0];
  assign spill     = miss & ~free_any & fifo_busy & mapped_vec[ent[0][IDX_W-1:0]];
  assign in_fifo   = sh[NUM_REGS];

  assign bank_cmd.take = take_ok;
  assign bank_cmd.drop = rel;
  assign bank_cmd.idx  = rel ? found_idx : tgt;

  // move target to the back: same fill if it was already queued
  assign fifo_cmd.upd   = take_ok;
  assign fifo_cmd.key   = tgt;
  assign fifo_cmd.count = count_r;
  assign fifo_cmd.wpos  = in_fifo ? count_r - rsmfs_pkg::CNT_W'(1) : count_r;

  assign count_nxt = (take_ok && !in_fifo) ? count_r + rsmfs_pkg::CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // output register
  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg_index_r   <= found ? found_idx : (take_ok ? tgt : '0);
      out_hit_r         <= found;
      out_spill_valid_r <= spill;
      out_spill_slot_r  <= spill ? rd_slot : '0;
      out_load_valid_r  <= take_ok & ~in_no_load;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_index   = out_reg_index_r;
  assign out_hit         = out_hit_r;
  assign out_spill_valid = out_spill_valid_r;
  assign out_spill_slot  = out_spill_slot_r;
  assign out_load_valid  = out_load_valid_r;

  // fill never passes the register count
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rsmfs_pkg::CNT_W'(NUM_REGS))
    else $error("fifo fill above register count");

  // free and mapped stay complementary
  a_free_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    free_vec == ~mapped_vec)
    else $error("free and mapped flags disagree");

  // with no free register every register is queued
  a_full_when_none_free: assert property (@(posedge clk) disable iff (!rst_n)
    (free_vec == '0) |-> (count_r == rsmfs_pkg::CNT_W'(NUM_REGS)))
    else $error("no free register but fifo not full");

  // a hit never spills or loads
  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (!out_load_valid_r && !out_spill_valid_r))
    else $error("hit with spill or load");

endmodule

// File: tb/register_slot_map_fifo_spill_unit_tb.sv
module register_slot_map_fifo_spill_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS    = 14;
  localparam int SLOT_BITS   = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 60;
  localparam int POOL_SIZE   = 20;

  typedef logic [SLOT_BITS-1:0] slot_t;

  typedef struct {
    rsmfs_pkg::reg_idx_t reg_index;
    logic                hit;
    logic                spill_valid;
    slot_t               spill_slot;
    logic                load_valid;
  } map_result_t;

  // predicts the register map and holds the results still owed by the block
  class slot_map_scoreboard;
    slot_t               held_slot[NUM_REGS];
    bit                  mapped[NUM_REGS];
    bit                  unused_reg[NUM_REGS];
    rsmfs_pkg::reg_idx_t fifo_q[$];
    map_result_t         owed[$];
    int errors = 0;
    int hits = 0;
    int spills = 0;
    int loads = 0;
    int releases = 0;
    int idle_releases = 0;

    function new();
      for (int r = 0; r < NUM_REGS; r++) begin
        held_slot[r]  = '0;
        mapped[r]     = 1'b0;
        unused_reg[r] = 1'b1;
      end
    endfunction

    // update the map for one accepted request and queue the result it owes
    function void note_request(rsmfs_pkg::op_t op, slot_t slot, logic no_load);
      map_result_t res;
      int found;
      int pick;
      string txt_r;
      string txt_pick;
      res = '{default: '0};
      found = -1;
      for (int r = 0; r < NUM_REGS; r++) begin
        if (found < 0 && mapped[r] && held_slot[r] == slot) found = r;
      end
      if (op == rsmfs_pkg::OP_RELEASE) begin
        if (found >= 0) begin
          mapped[found]     = 1'b0;
          unused_reg[found] = 1'b1;
          res.reg_index     = rsmfs_pkg::reg_idx_t'(found);
          res.hit           = 1'b1;
          releases++;
        end else begin
          idle_releases++;
        end
      end else if (found >= 0) begin
        res.reg_index = rsmfs_pkg::reg_idx_t'(found);
        res.hit       = 1'b1;
        hits++;
      end else begin
        // free register whose number comes first as decimal text
        pick = -1;
        for (int r = 0; r < NUM_REGS; r++) begin
          if (unused_reg[r]) begin
            txt_r = $sformatf("%0d", r);
            if (pick >= 0) txt_pick = $sformatf("%0d", pick);
            if (pick < 0 || txt_r < txt_pick) pick = r;
          end
        end
        if (pick >= 0) begin
          unused_reg[pick] = 1'b0;
          for (int i = fifo_q.size() - 1; i >= 0; i--) begin
            if (fifo_q[i] == rsmfs_pkg::reg_idx_t'(pick)) fifo_q.delete(i);
          end
          if (fifo_q.size() < NUM_REGS) fifo_q.push_back(rsmfs_pkg::reg_idx_t'(pick));
        end else if (fifo_q.size() > 0) begin
          // nothing free: evict the oldest and write back its slot
          pick = int'(fifo_q.pop_front());
          if (mapped[pick]) begin
            res.spill_valid = 1'b1;
            res.spill_slot  = held_slot[pick];
            spills++;
          end
          fifo_q.push_back(rsmfs_pkg::reg_idx_t'(pick));
        end
        if (pick >= 0) begin
          mapped[pick]    = 1'b1;
          held_slot[pick] = slot;
          res.reg_index   = rsmfs_pkg::reg_idx_t'(pick);
          res.load_valid  = !no_load;
          if (!no_load) loads++;
        end
      end
      owed.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // compare one result beat against the oldest owed result
    function void check_result(map_result_t got);
      map_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual reg_index %0h",
                 $time, got.reg_index);
        return;
      end
      want = owed.pop_front();
      compare_field("reg_index", want.reg_index, got.reg_index);
      compare_field("hit", want.hit, got.hit);
      compare_field("spill_valid", want.spill_valid, got.spill_valid);
      compare_field("spill_slot", want.spill_slot, got.spill_slot);
      compare_field("load_valid", want.load_valid, got.load_valid);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = 1'b0;
  slot_t               in_mem_slot = '0;
  logic                in_no_load = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsmfs_pkg::reg_idx_t out_reg_index;
  logic                out_hit;
  logic                out_spill_valid;
  slot_t               out_spill_slot;
  logic                out_load_valid;

  slot_map_scoreboard sb = new();
  int beats_in = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_token = 0;
  int cycle_count = 0;

  register_slot_map_fifo_spill_unit #(
    .NUM_REGS (NUM_REGS),
    .SLOT_BITS(SLOT_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_mem_slot    (in_mem_slot),
    .in_no_load     (in_no_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reg_index  (out_reg_index),
    .out_hit        (out_hit),
    .out_spill_valid(out_spill_valid),
    .out_spill_slot (out_spill_slot),
    .out_load_valid (out_load_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    map_result_t got;
    if (rst_n && in_valid && !in_stall) begin
      sb.note_request(rsmfs_pkg::op_t'(in_op), in_mem_slot, in_no_load);
      beats_in++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got.reg_index   = out_reg_index;
      got.hit         = out_hit;
      got.spill_valid = out_spill_valid;
      got.spill_slot  = out_spill_slot;
      got.load_valid  = out_load_valid;
      sb.check_result(got);
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // offer one request beat, called at a falling edge, returns once accepted
  task automatic send_beat(rsmfs_pkg::op_t op, slot_t slot, logic no_load);
    int seen;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = op;
    in_mem_slot = slot;
    in_no_load  = no_load;
    seen = beats_in;
    do @(negedge clk); while (beats_in == seen);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  initial begin
    slot_t          pool[POOL_SIZE];
    int             phase_beats;
    rsmfs_pkg::op_t op;
    slot_t          slot;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, hit, both kinds of release, fill, evict with spill
    send_beat(rsmfs_pkg::OP_GET, '0, 1'b0);
    send_beat(rsmfs_pkg::OP_GET, '1, 1'b1);
    send_beat(rsmfs_pkg::OP_GET, '0, 1'b1);
    send_beat(rsmfs_pkg::OP_RELEASE, '1, 1'b0);
    send_beat(rsmfs_pkg::OP_RELEASE, '1, 1'b1);
    for (int i = 1; i <= NUM_REGS; i++) send_beat(rsmfs_pkg::OP_GET, slot_t'(i), i[0]);
    send_beat(rsmfs_pkg::OP_GET, '0, 1'b0);
    send_beat(rsmfs_pkg::OP_RELEASE, 16'h5555, 1'b0);
    send_beat(rsmfs_pkg::OP_GET, 16'haaaa, 1'b1);
    send_beat(rsmfs_pkg::OP_RELEASE, 16'haaaa, 1'b0);
    send_beat(rsmfs_pkg::OP_GET, 16'h5555, 1'b0);
    wait_drained();

    // a small slot pool keeps hits, releases and evictions all frequent
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = slot_t'($urandom_range(65535));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 18;
          sink_stall_pct = 60;
        end
        1: begin
          src_idle_pct   = 60;
          sink_stall_pct = 18;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          hold_token++;
        end
      endcase
      phase_beats = (phase == 2) ? 234 : 233;
      repeat (phase_beats) begin
        op   = ($urandom_range(99) < 20) ? rsmfs_pkg::OP_RELEASE : rsmfs_pkg::OP_GET;
        slot = ($urandom_range(99) < 88) ? pool[$urandom_range(POOL_SIZE - 1)]
                                         : slot_t'($urandom_range(65535));
        send_beat(op, slot, 1'($urandom_range(1)));
      end
      // sender pauses until every owed result is back
      wait_drained();
    end

    repeat (8) @(negedge clk);
    $display("covered %0d requests under three idle mixes and a %0d-cycle output hold-off",
             beats_in, LONG_HOLD);
    $display("%0d hits, %0d spills, %0d loads, %0d mapped and %0d unmapped releases",
             sb.hits, sb.spills, sb.loads, sb.releases, sb.idle_releases);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
